// ===== rtl/core/lfu_pkg.sv =====
// Shared types and constants for the LFU page replacement core.
`timescale 1ns / 1ps
package lfu_pkg;

  localparam int PAGE_W = 8;
  localparam int CNT_W = 16;
  localparam int FAULT_W = 32;
  localparam int FC_W = 4;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [FC_W-1:0] FRAME_COUNT_RST = 4'd8;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // Register word index taken from paddr[2]
  localparam logic REG_FRAME_COUNT = 1'b0;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic rotate;
    logic upd;
    logic append;
    logic evict;
  } frame_op_t;

endpackage

// ===== rtl/core/lfu_count_mem.sv =====
// Use count memory: one write port, one registered read port.
`timescale 1ns / 1ps
module lfu_count_mem #(
  parameter int PAGES = 256,
  parameter int IW = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IW-1:0]        waddr,
  input  lfu_pkg::cnt_t        wdata,
  input  logic [IW-1:0]        raddr,
  output lfu_pkg::cnt_t        rdata
);

  lfu_pkg::cnt_t mem_r [PAGES];
  lfu_pkg::cnt_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/lfu_frame_file.sv =====
// Resident frame list in insertion order, with rotate, append and evict.
`timescale 1ns / 1ps
module lfu_frame_file #(
  parameter int FRAMES = 8,
  parameter int IW = 8,
  parameter int UW = 4,
  parameter int VW = 3
) (
  input  logic                 clk,
  input  lfu_pkg::frame_op_t   op,
  input  logic [UW-1:0]        used,
  input  logic [VW-1:0]        victim,
  input  lfu_pkg::page_t       new_page,
  input  logic [IW-1:0]        new_idx,
  input  lfu_pkg::cnt_t        new_cnt,
  output lfu_pkg::page_t       head_page,
  output logic [IW-1:0]        head_idx,
  output lfu_pkg::cnt_t        head_cnt
);

  lfu_pkg::page_t pages_r [FRAMES];
  logic [IW-1:0]  idxs_r  [FRAMES];
  lfu_pkg::cnt_t  cnts_r  [FRAMES];

  lfu_pkg::page_t pages_nxt [FRAMES];
  logic [IW-1:0]  idxs_nxt  [FRAMES];
  lfu_pkg::cnt_t  cnts_nxt  [FRAMES];

  logic [UW-1:0] used_m1;
  lfu_pkg::cnt_t head_cnt_eff;

  assign used_m1 = used - UW'(1);
  assign head_cnt_eff = op.upd ? new_cnt : cnts_r[0];

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      pages_nxt[i] = pages_r[i];
      idxs_nxt[i] = idxs_r[i];
      cnts_nxt[i] = cnts_r[i];
      if (op.rotate) begin
        if (UW'(i) == used_m1) begin
          pages_nxt[i] = pages_r[0];
          idxs_nxt[i] = idxs_r[0];
          cnts_nxt[i] = head_cnt_eff;
        end else if (UW'(i) < used_m1 && i + 1 < FRAMES) begin
          pages_nxt[i] = pages_r[(i + 1) % FRAMES];
          idxs_nxt[i] = idxs_r[(i + 1) % FRAMES];
          cnts_nxt[i] = cnts_r[(i + 1) % FRAMES];
        end
      end else if (op.append) begin
        if (UW'(i) == used) begin
          pages_nxt[i] = new_page;
          idxs_nxt[i] = new_idx;
          cnts_nxt[i] = new_cnt;
        end
      end else if (op.evict) begin
        if (UW'(i) == used_m1) begin
          pages_nxt[i] = new_page;
          idxs_nxt[i] = new_idx;
          cnts_nxt[i] = new_cnt;
        end else if (VW'(i) >= victim && UW'(i) < used_m1 && i + 1 < FRAMES) begin
          pages_nxt[i] = pages_r[(i + 1) % FRAMES];
          idxs_nxt[i] = idxs_r[(i + 1) % FRAMES];
          cnts_nxt[i] = cnts_r[(i + 1) % FRAMES];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FRAMES; i++) begin
      pages_r[i] <= pages_nxt[i];
      idxs_r[i] <= idxs_nxt[i];
      cnts_r[i] <= cnts_nxt[i];
    end
  end

  assign head_page = pages_r[0];
  assign head_idx = idxs_r[0];
  assign head_cnt = cnts_r[0];

endmodule

// ===== rtl/core/lfu_page_replacement_core.sv =====
// Top level of the LFU page replacement core: sequencer, scan unit and config port.
//
// Input channel: in_valid / in_stall carry one page reference word (in_page).
// Output channel: out_valid / out_stall carry one result word per reference:
// out_page_fault, out_evicted_valid, out_evicted_page, out_fault_total.
// A word is accepted at a rising edge with valid high and stall low.
// Each reference passes through these steps from acceptance to the result
// showing on the output register: the count memory is read at the
// accepting edge, then the count is updated, the resident frames are
// scanned in turn on the shared compare unit, the frame list is updated
// and the output register is loaded. The next reference is accepted only
// after the result is loaded and the sequencer is idle again, so it may be
// taken while that result is still waiting.
// A stalled result holds the output register; the sequencer waits for it
// to drain before loading the next result.
// After reset the count memory is cleared one entry a cycle, with in_stall
// high; frame_count writes are taken throughout.
// frame_count lies at byte address 0 of the APB port, reset value 8.
`timescale 1ns / 1ps
module lfu_page_replacement_core #(
  parameter int FRAMES = 8,
  parameter int PAGES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_page,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_page_fault,
  output logic                          out_evicted_valid,
  output logic [7:0]                    out_evicted_page,
  output logic [31:0]                   out_fault_total,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfu_pkg::APB_AW-1:0]    paddr,
  input  logic [lfu_pkg::APB_DW-1:0]    pwdata,
  output logic [lfu_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int IW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int UW = $clog2(FRAMES + 1);
  localparam int VW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int LW = (UW > lfu_pkg::FC_W) ? UW : lfu_pkg::FC_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_INC  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  function automatic logic [IW-1:0] page_index(input lfu_pkg::page_t p);
    logic [31:0] rem;
    rem = {24'd0, p};
    for (int k = 7; k >= 0; k--) begin
      if (rem >= (32'(PAGES) << k)) begin
        rem = rem - (32'(PAGES) << k);
      end
    end
    return rem[IW-1:0];
  endfunction

  logic [2:0]                  state_r, state_nxt;
  logic [IW-1:0]               clr_addr_r, clr_addr_nxt;
  lfu_pkg::page_t              page_r, page_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  lfu_pkg::cnt_t               newcnt_r, newcnt_nxt;
  logic [UW-1:0]               scan_r, scan_nxt;
  logic                        hit_r, hit_nxt;
  lfu_pkg::cnt_t               min_cnt_r, min_cnt_nxt;
  logic [VW-1:0]               victim_r, victim_nxt;
  lfu_pkg::page_t              min_page_r, min_page_nxt;
  logic [UW-1:0]               used_r, used_nxt;
  logic [lfu_pkg::FAULT_W-1:0] fault_r, fault_nxt;
  logic [lfu_pkg::FC_W-1:0]    fc_r, fc_nxt;
  logic                        res_fault_r, res_fault_nxt;
  logic                        res_ev_r, res_ev_nxt;
  lfu_pkg::page_t              res_ev_page_r, res_ev_page_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_fault_r, out_fault_nxt;
  logic                        out_ev_r, out_ev_nxt;
  lfu_pkg::page_t              out_ev_page_r, out_ev_page_nxt;
  logic [lfu_pkg::FAULT_W-1:0] out_total_r, out_total_nxt;

  logic                        mem_we;
  logic [IW-1:0]               mem_waddr;
  lfu_pkg::cnt_t               mem_wdata;
  logic [IW-1:0]               mem_raddr;
  lfu_pkg::cnt_t               mem_rdata;
  lfu_pkg::cnt_t               inc_cnt;

  lfu_pkg::frame_op_t          fop;
  lfu_pkg::page_t              head_page;
  logic [IW-1:0]               head_idx;
  lfu_pkg::cnt_t               head_cnt;
  lfu_pkg::cnt_t               head_cnt_eff;
  logic                        head_match;
  logic                        head_less;

  logic [LW-1:0]               limit;
  logic                        cfg_wr;

  lfu_count_mem #(
    .PAGES(PAGES),
    .IW(IW)
  ) u_count_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  lfu_frame_file #(
    .FRAMES(FRAMES),
    .IW(IW),
    .UW(UW),
    .VW(VW)
  ) u_frame_file (
    .clk(clk),
    .op(fop),
    .used(used_r),
    .victim(victim_r),
    .new_page(page_r),
    .new_idx(idx_r),
    .new_cnt(newcnt_r),
    .head_page(head_page),
    .head_idx(head_idx),
    .head_cnt(head_cnt)
  );

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == lfu_pkg::REG_FRAME_COUNT);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lfu_pkg::REG_FRAME_COUNT) ?
                  lfu_pkg::APB_DW'(fc_r) : '0;

  always_comb begin
    if (fc_r == '0) begin
      limit = LW'(1);
    end else if (LW'(fc_r) > LW'(FRAMES)) begin
      limit = LW'(FRAMES);
    end else begin
      limit = LW'(fc_r);
    end
  end

  assign mem_raddr = page_index(in_page);
  assign inc_cnt = (mem_rdata == lfu_pkg::CNT_MAX) ? mem_rdata : mem_rdata + 1'b1;

  // Shared compare unit: page match, alias update and minimum search
  assign head_match = (head_page == page_r);
  assign head_cnt_eff = (head_idx == idx_r) ? newcnt_r : head_cnt;
  assign head_less = (scan_r == '0) || (head_cnt_eff < min_cnt_r);

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    clr_addr_nxt = clr_addr_r;
    page_nxt = page_r;
    idx_nxt = idx_r;
    newcnt_nxt = newcnt_r;
    scan_nxt = scan_r;
    hit_nxt = hit_r;
    min_cnt_nxt = min_cnt_r;
    victim_nxt = victim_r;
    min_page_nxt = min_page_r;
    used_nxt = used_r;
    fault_nxt = fault_r;
    fc_nxt = cfg_wr ? pwdata[lfu_pkg::FC_W-1:0] : fc_r;
    res_fault_nxt = res_fault_r;
    res_ev_nxt = res_ev_r;
    res_ev_page_nxt = res_ev_page_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_fault_nxt = out_fault_r;
    out_ev_nxt = out_ev_r;
    out_ev_page_nxt = out_ev_page_r;
    out_total_nxt = out_total_r;
    mem_we = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = newcnt_r;
    fop = '0;

    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == IW'(PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          page_nxt = in_page;
          idx_nxt = mem_raddr;
          state_nxt = S_INC;
        end
      end
      S_INC: begin
        mem_we = 1'b1;
        mem_wdata = inc_cnt;
        newcnt_nxt = inc_cnt;
        scan_nxt = '0;
        hit_nxt = 1'b0;
        victim_nxt = '0;
        state_nxt = (used_r == '0) ? S_UPD : S_SCAN;
      end
      S_SCAN: begin
        fop.rotate = 1'b1;
        fop.upd = (head_idx == idx_r);
        if (head_match) begin
          hit_nxt = 1'b1;
        end
        if (head_less) begin
          min_cnt_nxt = head_cnt_eff;
          victim_nxt = scan_r[VW-1:0];
          min_page_nxt = head_page;
        end
        scan_nxt = scan_r + 1'b1;
        if (scan_r == used_r - 1'b1) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        res_fault_nxt = !hit_r;
        res_ev_nxt = 1'b0;
        res_ev_page_nxt = '0;
        if (!hit_r) begin
          if (fault_r != lfu_pkg::FAULT_MAX) begin
            fault_nxt = fault_r + 1'b1;
          end
          if (LW'(used_r) < limit) begin
            fop.append = 1'b1;
            used_nxt = used_r + 1'b1;
          end else if (used_r != '0) begin
            fop.evict = 1'b1;
            res_ev_nxt = 1'b1;
            res_ev_page_nxt = min_page_r;
          end
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_fault_nxt = res_fault_r;
          out_ev_nxt = res_ev_r;
          out_ev_page_nxt = res_ev_page_r;
          out_total_nxt = fault_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_addr_r <= '0;
      used_r <= '0;
      fault_r <= '0;
      fc_r <= lfu_pkg::FRAME_COUNT_RST;
      out_valid_r <= 1'b0;
      hit_r <= 1'b0;
      scan_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      used_r <= used_nxt;
      fault_r <= fault_nxt;
      fc_r <= fc_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r <= hit_nxt;
      scan_r <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    idx_r <= idx_nxt;
    newcnt_r <= newcnt_nxt;
    min_cnt_r <= min_cnt_nxt;
    victim_r <= victim_nxt;
    min_page_r <= min_page_nxt;
    res_fault_r <= res_fault_nxt;
    res_ev_r <= res_ev_nxt;
    res_ev_page_r <= res_ev_page_nxt;
    out_fault_r <= out_fault_nxt;
    out_ev_r <= out_ev_nxt;
    out_ev_page_r <= out_ev_page_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_page_fault = out_fault_r;
  assign out_evicted_valid = out_ev_r;
  assign out_evicted_page = out_ev_page_r;
  assign out_fault_total = out_total_r;

endmodule

// ===== tb/lfu_page_replacement_core_tb.sv =====
// Self-checking testbench for the LFU page replacement core with its own LFU predictor.
`timescale 1ns / 1ps
module lfu_page_replacement_core_tb;

  localparam int FRAMES = 8;
  localparam int PAGES = 256;
  localparam int RAND_PER_PHASE = 320;

  typedef struct packed {
    logic                        fault;
    logic                        ev_valid;
    lfu_pkg::page_t              ev_page;
    logic [lfu_pkg::FAULT_W-1:0] total;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lfu_pkg::page_t in_page = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_page_fault;
  logic out_evicted_valid;
  lfu_pkg::page_t out_evicted_page;
  logic [lfu_pkg::FAULT_W-1:0] out_fault_total;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lfu_pkg::APB_AW-1:0] paddr = '0;
  logic [lfu_pkg::APB_DW-1:0] pwdata = '0;
  logic [lfu_pkg::APB_DW-1:0] prdata;
  logic pready;

  // predictor state
  lfu_pkg::page_t resident [FRAMES];
  int resident_cnt;
  lfu_pkg::cnt_t use_count [PAGES];
  logic [lfu_pkg::FAULT_W-1:0] faults_seen;
  logic [lfu_pkg::FC_W-1:0] frame_limit_reg;

  lfu_pkg::page_t page_refs [$];
  outcome_t awaited_outcomes [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int refs_sent = 0;
  int words_checked = 0;
  int faults_checked = 0;
  int evictions_checked = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  lfu_page_replacement_core #(
    .FRAMES(FRAMES),
    .PAGES(PAGES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_page(in_page),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_page_fault(out_page_fault),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page(out_evicted_page),
    .out_fault_total(out_fault_total),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic int count_idx(lfu_pkg::page_t pg);
    return int'(pg) % PAGES;
  endfunction

  function automatic outcome_t replace_page(lfu_pkg::page_t pg);
    outcome_t o;
    bit hit;
    int lim;
    int victim;
    lfu_pkg::cnt_t minc;
    o = '0;
    hit = 1'b0;
    if (use_count[count_idx(pg)] != lfu_pkg::CNT_MAX)
      use_count[count_idx(pg)] = use_count[count_idx(pg)] + 1'b1;
    for (int i = 0; i < resident_cnt; i++)
      if (resident[i] == pg) hit = 1'b1;
    if (!hit) begin
      if (faults_seen != lfu_pkg::FAULT_MAX) faults_seen = faults_seen + 1'b1;
      lim = int'(frame_limit_reg);
      if (lim == 0) lim = 1;
      if (lim > FRAMES) lim = FRAMES;
      if (resident_cnt < lim) begin
        resident[resident_cnt] = pg;
        resident_cnt++;
      end else if (resident_cnt > 0) begin
        victim = 0;
        minc = use_count[count_idx(resident[0])];
        for (int i = 1; i < resident_cnt; i++)
          if (use_count[count_idx(resident[i])] < minc) begin
            minc = use_count[count_idx(resident[i])];
            victim = i;
          end
        o.ev_valid = 1'b1;
        o.ev_page = resident[victim];
        for (int i = victim; i + 1 < resident_cnt; i++) resident[i] = resident[i + 1];
        resident[resident_cnt - 1] = pg;
      end
    end
    o.fault = !hit;
    o.total = faults_seen;
    return o;
  endfunction

  task automatic queue_ref(input lfu_pkg::page_t pg);
    page_refs.insert(page_refs.size(), pg);
  endtask

  // driver: offer queued page references, hold while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        awaited_outcomes.insert(awaited_outcomes.size(), replace_page(in_page));
        refs_sent++;
      end
      if (page_refs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_page <= page_refs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin : monitor
    outcome_t exp_o;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_outcomes.size() == 0) begin
        $display("%0t: unexpected result word fault=%0b ev=%0b page=%0h total=%0d", $time,
                 out_page_fault, out_evicted_valid, out_evicted_page, out_fault_total);
        errors++;
      end else begin
        exp_o = awaited_outcomes.pop_front();
        words_checked++;
        if (exp_o.fault) faults_checked++;
        if (exp_o.ev_valid) evictions_checked++;
        if (out_page_fault !== exp_o.fault) begin
          $display("%0t: page_fault expected %0b actual %0b", $time, exp_o.fault,
                   out_page_fault);
          errors++;
        end
        if (out_evicted_valid !== exp_o.ev_valid) begin
          $display("%0t: evicted_valid expected %0b actual %0b", $time, exp_o.ev_valid,
                   out_evicted_valid);
          errors++;
        end
        if (out_evicted_page !== exp_o.ev_page) begin
          $display("%0t: evicted_page expected %0h actual %0h", $time, exp_o.ev_page,
                   out_evicted_page);
          errors++;
        end
        if (out_fault_total !== exp_o.total) begin
          $display("%0t: fault_total expected %0d actual %0d", $time, exp_o.total,
                   out_fault_total);
          errors++;
        end
      end
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  task automatic set_frame_count(input logic [lfu_pkg::FC_W-1:0] fc);
    logic [lfu_pkg::APB_DW-1:0] rd;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {lfu_pkg::REG_FRAME_COUNT, 2'b00};
    pwdata <= lfu_pkg::APB_DW'(fc);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    frame_limit_reg = fc;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== lfu_pkg::APB_DW'(fc)) begin
      $display("%0t: frame_count read expected %0d actual %0d", $time, fc, rd);
      errors++;
    end
  endtask

  task automatic drain;
    while (page_refs.size() != 0 || in_valid || awaited_outcomes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [lfu_pkg::FC_W-1:0] fc_plan [6];
    lfu_pkg::page_t base;
    fc_plan = '{4'd8, 4'd1, 4'd5, 4'd15, 4'd2, 4'd0};
    for (int i = 0; i < FRAMES; i++) resident[i] = '0;
    for (int i = 0; i < PAGES; i++) use_count[i] = '0;
    resident_cnt = 0;
    faults_seen = '0;
    frame_limit_reg = lfu_pkg::FRAME_COUNT_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // zero frame count behaves as one frame
    set_frame_count(4'd0);
    queue_ref(8'h00);
    queue_ref(8'hFF);
    queue_ref(8'hFF);
    queue_ref(8'h00);
    drain();

    // oversized frame count clamps to the frame array
    set_frame_count(4'd15);
    for (int p = 1; p <= 7; p++) queue_ref(lfu_pkg::page_t'(p));
    queue_ref(8'h80);
    queue_ref(8'h81);
    queue_ref(8'h01);
    drain();

    // lower the limit while full: replace one for one
    set_frame_count(4'd3);
    queue_ref(8'h55);
    queue_ref(8'hAA);
    queue_ref(8'h55);
    queue_ref(8'h02);
    queue_ref(8'hFE);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 80 : 0;
      recv_stall_pct = (ph < 2) ? 80 : (ph < 4) ? 10 : 0;
      set_frame_count(fc_plan[ph]);
      base = '0;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (n % 40 == 0) base = lfu_pkg::page_t'($urandom_range(0, 255));
        if ($urandom_range(99) < 80) queue_ref(base + lfu_pkg::page_t'($urandom_range(0, 11)));
        else queue_ref(lfu_pkg::page_t'($urandom));
      end
      if (ph == 0) hold_go = 1'b1;
      drain();
    end

    $display("Sent %0d references, checked %0d result words: %0d faults, %0d evictions.",
             refs_sent, words_checked, faults_checked, evictions_checked);
    $display("Covered frame counts 0 to 15, limit cuts while full and a long output hold.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lfu_pkg.sv
rtl/core/lfu_count_mem.sv
rtl/core/lfu_frame_file.sv
rtl/core/lfu_page_replacement_core.sv
tb/lfu_page_replacement_core_tb.sv
